>>> hw/rtl/ckbr_pkg.sv
`timescale 1ns / 1ps

package ckbr_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_ENABLE        = 3'd0,
        CFG_KEY_COLOR     = 3'd1,
        CFG_NEAR_TOL      = 3'd2,
        CFG_FAR_TOL       = 3'd3,
        CFG_REPLACE_MODE  = 3'd4,
        CFG_REPLACE_COLOR = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KC_KEEP    = 2'd0,
        KC_BLEND   = 2'd1,
        KC_REPLACE = 2'd2
    } t_key_class;

    localparam int SQRT_STEPS = 17;
    localparam int DIV_STEPS  = 16;

    // channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [2:0][7:0] src;
        logic [2:0][7:0] bg;
    } t_pix;

    typedef struct packed {
        t_pix       pix;
        t_key_class kclass;
    } t_div_pay;

    function automatic logic [7:0] chroma_b(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [24:0] v;
        v = 25'd8388608 + {2'b00, b, 15'd0} - 25'(25'(r) * 25'd11059)
            - 25'(25'(g) * 25'd21709);
        return v[23:16];
    endfunction

    function automatic logic [7:0] chroma_r(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [24:0] v;
        v = 25'd8388608 + {2'b00, r, 15'd0} - 25'(25'(g) * 25'd27439)
            - 25'(25'(b) * 25'd5329);
        return v[23:16];
    endfunction

endpackage

>>> hw/rtl/ckbr_isqrt.sv
`timescale 1ns / 1ps

module ckbr_isqrt (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  ckbr_pkg::t_pix       i_pix,
    input  logic [16:0]          i_sq,
    output logic                 o_valid,
    output ckbr_pkg::t_pix       o_pix,
    output logic [16:0]          o_root
);

    logic [33:0]    r_v   [ckbr_pkg::SQRT_STEPS];
    logic [33:0]    r_res [ckbr_pkg::SQRT_STEPS];
    ckbr_pkg::t_pix r_pix [ckbr_pkg::SQRT_STEPS];
    logic           r_vld [ckbr_pkg::SQRT_STEPS];
    logic [33:0]    n_v   [ckbr_pkg::SQRT_STEPS];
    logic [33:0]    n_res [ckbr_pkg::SQRT_STEPS];

    // one root bit per stage; the radicand is sq << 16
    always_comb begin
        logic [33:0] pv;
        logic [33:0] pres;
        logic [33:0] bitv;
        logic [33:0] trial;
        for (int k = 0; k < ckbr_pkg::SQRT_STEPS; k++) begin
            if (k == 0) begin
                pv   = {1'b0, i_sq, 16'd0};
                pres = '0;
            end else begin
                pv   = r_v[k-1];
                pres = r_res[k-1];
            end
            bitv  = 34'd1 << (32 - 2 * k);
            trial = pres + bitv;
            if (pv >= trial) begin
                n_v[k]   = pv - trial;
                n_res[k] = (pres >> 1) + bitv;
            end else begin
                n_v[k]   = pv;
                n_res[k] = pres >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < ckbr_pkg::SQRT_STEPS; k++) begin
                r_v[k]   <= n_v[k];
                r_res[k] <= n_res[k];
                r_pix[k] <= (k == 0) ? i_pix : r_pix[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ckbr_pkg::SQRT_STEPS; k++) r_vld[k] <= 1'b0;
        end else if (i_adv) begin
            for (int k = 0; k < ckbr_pkg::SQRT_STEPS; k++)
                r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
        end
    end

    assign o_valid = r_vld[ckbr_pkg::SQRT_STEPS-1];
    assign o_pix   = r_pix[ckbr_pkg::SQRT_STEPS-1];
    assign o_root  = r_res[ckbr_pkg::SQRT_STEPS-1][16:0];

endmodule

>>> hw/rtl/ckbr_div.sv
`timescale 1ns / 1ps

module ckbr_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  ckbr_pkg::t_div_pay   i_pay,
    input  logic [16:0]          i_num,
    input  logic [8:0]           i_den,
    output logic                 o_valid,
    output ckbr_pkg::t_div_pay   o_pay,
    output logic [15:0]          o_quot
);

    logic [24:0]          r_rem  [ckbr_pkg::DIV_STEPS];
    logic [15:0]          r_quot [ckbr_pkg::DIV_STEPS];
    logic [8:0]           r_den  [ckbr_pkg::DIV_STEPS];
    ckbr_pkg::t_div_pay   r_pay  [ckbr_pkg::DIV_STEPS];
    logic                 r_vld  [ckbr_pkg::DIV_STEPS];
    logic [24:0]          n_rem  [ckbr_pkg::DIV_STEPS];
    logic [15:0]          n_quot [ckbr_pkg::DIV_STEPS];

    // quotient of (num << 8) / den, one bit per stage, msb first
    always_comb begin
        logic [24:0] prem;
        logic [15:0] pq;
        logic [8:0]  pden;
        logic [24:0] dsh;
        for (int k = 0; k < ckbr_pkg::DIV_STEPS; k++) begin
            if (k == 0) begin
                prem = {i_num, 8'd0};
                pq   = '0;
                pden = i_den;
            end else begin
                prem = r_rem[k-1];
                pq   = r_quot[k-1];
                pden = r_den[k-1];
            end
            dsh       = 25'(pden) << (ckbr_pkg::DIV_STEPS - 1 - k);
            n_quot[k] = pq;
            if (prem >= dsh) begin
                n_rem[k] = prem - dsh;
                n_quot[k][ckbr_pkg::DIV_STEPS-1-k] = 1'b1;
            end else begin
                n_rem[k] = prem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int k = 0; k < ckbr_pkg::DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_quot[k] <= n_quot[k];
                r_den[k]  <= (k == 0) ? i_den : r_den[k-1];
                r_pay[k]  <= (k == 0) ? i_pay : r_pay[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ckbr_pkg::DIV_STEPS; k++) r_vld[k] <= 1'b0;
        end else if (i_adv) begin
            for (int k = 0; k < ckbr_pkg::DIV_STEPS; k++)
                r_vld[k] <= (k == 0) ? i_valid : r_vld[k-1];
        end
    end

    assign o_valid = r_vld[ckbr_pkg::DIV_STEPS-1];
    assign o_pay   = r_pay[ckbr_pkg::DIV_STEPS-1];
    assign o_quot  = r_quot[ckbr_pkg::DIV_STEPS-1];

endmodule

>>> hw/rtl/chroma_key_background_replace_top.sv
`timescale 1ns / 1ps

// Chroma key with background replacement, one pixel per clock. Each pixel passes
// through two stages for chroma and squared distance, seventeen for the square
// root (one root bit each), one for classification, sixteen for the blend mask
// division (one quotient bit each), one for the mask products and one for the output
// register. A new pixel is taken every cycle unless the output is held; a held output
// stalls the whole pipeline in place. The user must write configuration through the
// cfg channel while no pixel is in flight; the block itself does not enforce it.

module chroma_key_background_replace_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_src_red,
    input  logic [7:0]  i_src_green,
    input  logic [7:0]  i_src_blue,
    input  logic [7:0]  i_back_red,
    input  logic [7:0]  i_back_green,
    input  logic [7:0]  i_back_blue,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_red,
    output logic [7:0]  o_out_green,
    output logic [7:0]  o_out_blue,
    output logic [1:0]  o_key_class
);

    logic        r_enable;
    logic [23:0] r_key_color;
    logic [8:0]  r_near;
    logic [8:0]  r_far;
    logic        r_replace_mode;
    logic [23:0] r_replace_color;

    logic adv;

    assign o_cfg_ready = 1'b1;
    assign adv         = !o_out_valid || i_out_ready;
    assign o_in_ready  = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= 1'b0;
            r_key_color     <= 24'd255;
            r_near          <= 9'd50;
            r_far           <= 9'd70;
            r_replace_mode  <= 1'b0;
            r_replace_color <= 24'd0;
        end else if (i_cfg_valid) begin
            case (ckbr_pkg::t_cfg_idx'(i_cfg_index))
                ckbr_pkg::CFG_ENABLE:        r_enable        <= i_cfg_data[0];
                ckbr_pkg::CFG_KEY_COLOR:     r_key_color     <= i_cfg_data;
                ckbr_pkg::CFG_NEAR_TOL:      r_near          <= i_cfg_data[8:0];
                ckbr_pkg::CFG_FAR_TOL:       r_far           <= i_cfg_data[8:0];
                ckbr_pkg::CFG_REPLACE_MODE:  r_replace_mode  <= i_cfg_data[0];
                ckbr_pkg::CFG_REPLACE_COLOR: r_replace_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: chroma of source and key
    logic           r1_vld;
    ckbr_pkg::t_pix r1_pix;
    ckbr_pkg::t_pix n1_pix;
    logic [7:0]     r1_scb, r1_scr, r1_kcb, r1_kcr;

    always_comb begin
        n1_pix.src = {i_src_blue, i_src_green, i_src_red};
        if (r_replace_mode)
            n1_pix.bg = {r_replace_color[7:0], r_replace_color[15:8],
                         r_replace_color[23:16]};
        else
            n1_pix.bg = {i_back_blue, i_back_green, i_back_red};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pix <= n1_pix;
            r1_scb <= ckbr_pkg::chroma_b(i_src_red, i_src_green, i_src_blue);
            r1_scr <= ckbr_pkg::chroma_r(i_src_red, i_src_green, i_src_blue);
            r1_kcb <= ckbr_pkg::chroma_b(r_key_color[23:16], r_key_color[15:8],
                                         r_key_color[7:0]);
            r1_kcr <= ckbr_pkg::chroma_r(r_key_color[23:16], r_key_color[15:8],
                                         r_key_color[7:0]);
        end
    end

    // stage 2: squared chroma distance
    logic           r2_vld;
    ckbr_pkg::t_pix r2_pix;
    logic [16:0]    r2_sq;
    logic signed [8:0]  dcb, dcr;
    logic signed [17:0] pcb, pcr;

    always_comb begin
        dcb = $signed({1'b0, r1_kcb}) - $signed({1'b0, r1_scb});
        dcr = $signed({1'b0, r1_kcr}) - $signed({1'b0, r1_scr});
        pcb = dcb * dcb;
        pcr = dcr * dcr;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_pix <= r1_pix;
            r2_sq  <= {1'b0, pcb[15:0]} + {1'b0, pcr[15:0]};
        end
    end

    logic           q_vld;
    ckbr_pkg::t_pix q_pix;
    logic [16:0]    q_root;

    ckbr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r2_vld),
        .i_pix   (r2_pix),
        .i_sq    (r2_sq),
        .o_valid (q_vld),
        .o_pix   (q_pix),
        .o_root  (q_root)
    );

    // stage 3: classify against the tolerances
    logic               r3_vld;
    ckbr_pkg::t_div_pay r3_pay;
    logic [16:0]        r3_num;
    logic [8:0]         r3_den;
    logic [16:0]        nearq, farq;
    ckbr_pkg::t_key_class n3_class;

    always_comb begin
        nearq = {r_near, 8'd0};
        farq  = {r_far, 8'd0};
        // distance exactly at near (below far) gives a full mask, so it replaces too
        if (!r_enable)
            n3_class = ckbr_pkg::KC_KEEP;
        else if (q_root < nearq || (q_root == nearq && q_root < farq))
            n3_class = ckbr_pkg::KC_REPLACE;
        else if (q_root < farq)
            n3_class = ckbr_pkg::KC_BLEND;
        else
            n3_class = ckbr_pkg::KC_KEEP;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_pay.pix    <= q_pix;
            r3_pay.kclass <= n3_class;
            r3_num        <= farq - q_root;
            r3_den        <= r_far - r_near;
        end
    end

    logic               d_vld;
    ckbr_pkg::t_div_pay d_pay;
    logic [15:0]        d_quot;

    ckbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r3_vld),
        .i_pay   (r3_pay),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .o_valid (d_vld),
        .o_pay   (d_pay),
        .o_quot  (d_quot)
    );

    // stage 4: mask products with key and background
    logic               r4_vld;
    ckbr_pkg::t_div_pay r4_pay;
    logic [23:0]        r4_mk [3];
    logic [23:0]        r4_mb [3];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_pay <= d_pay;
            for (int j = 0; j < 3; j++) begin
                r4_mk[j] <= 24'(d_quot) * 24'(r_key_color[8*(2-j) +: 8]);
                r4_mb[j] <= 24'(d_quot) * 24'(d_pay.pix.bg[j]);
            end
        end
    end

    // output stage: for blend, subtract key, add background, saturate; replace takes the background, keep the source
    logic [2:0][7:0] n_out;
    logic [2:0][7:0] r_out;
    logic [1:0]      r_out_class;
    logic            r_out_vld;

    always_comb begin
        logic [23:0] cs;
        logic [7:0]  base;
        logic [8:0]  sum;
        for (int j = 0; j < 3; j++) begin
            cs   = {r4_pay.pix.src[j], 16'd0};
            base = (r4_mk[j] >= cs) ? 8'd0 : 8'((cs - r4_mk[j]) >> 16);
            sum  = {1'b0, base} + {1'b0, r4_mb[j][23:16]};
            case (r4_pay.kclass)
                ckbr_pkg::KC_REPLACE: n_out[j] = r4_pay.pix.bg[j];
                ckbr_pkg::KC_BLEND:   n_out[j] = sum[8] ? 8'hFF : sum[7:0];
                default:              n_out[j] = r4_pay.pix.src[j];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out       <= n_out;
            r_out_class <= r4_pay.kclass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r1_vld    <= i_in_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= q_vld;
            r4_vld    <= d_vld;
            r_out_vld <= r4_vld;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_red   = r_out[0];
    assign o_out_green = r_out[1];
    assign o_out_blue  = r_out[2];
    assign o_key_class = r_out_class;

endmodule

>>> tb/tb_chroma_key_background_replace_top.sv
`timescale 1ns / 1ps

module tb_chroma_key_background_replace_top;

    localparam int PIPE_LAT  = 38;
    localparam int N_RANDOM  = 1000;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        ckbr_pkg::t_key_class kclass;
    } t_result;

    typedef struct {
        logic [7:0] sr, sg, sb, br, bg, bb;
        logic       has_exp;
        t_result    exp;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_src_red, i_src_green, i_src_blue;
    logic [7:0]  i_back_red, i_back_green, i_back_blue;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_red, o_out_green, o_out_blue;
    logic [1:0]  o_key_class;

    chroma_key_background_replace_top DUT (.*);

    // shadow copy of the configuration
    logic        sh_enable;
    logic [23:0] sh_key;
    logic [8:0]  sh_near, sh_far;
    logic        sh_mode;
    logic [23:0] sh_repl;

    t_result pixel_q[$];
    int      mismatches;
    int      n_checked;
    int      n_blend, n_repl;
    longint  cycles;
    bit      no_idle;
    bit      rx_hold;
    int      rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [7:0] cb_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0] v;
        v = 32'd8388608 + 32'd32768 * b - 32'd11059 * r - 32'd21709 * g;
        return v[23:16];
    endfunction

    function automatic logic [7:0] cr_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [31:0] v;
        v = 32'd8388608 + 32'd32768 * r - 32'd27439 * g - 32'd5329 * b;
        return v[23:16];
    endfunction

    function automatic longint isqrt(longint v);
        longint res, bitv;
        res = 0;
        bitv = longint'(1) << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] k, logic [7:0] b,
                                               longint mask);
        longint a, base, sum;
        a = longint'(c) * 65536 - mask * longint'(k);
        base = (a <= 0) ? 0 : (a >>> 16);
        sum = (base * 65536 + mask * longint'(b)) >>> 16;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function automatic t_result key_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                                          logic [7:0] br, logic [7:0] bg, logic [7:0] bb);
        t_result res;
        logic [7:0] rr, rg, rb, kr, kg, kb;
        int dcb, dcr;
        longint dist_q, nq, fq, mask;
        res = '{sr, sg, sb, ckbr_pkg::KC_KEEP};
        if (!sh_enable) return res;
        {kr, kg, kb} = sh_key;
        if (sh_mode) {rr, rg, rb} = sh_repl;
        else {rr, rg, rb} = {br, bg, bb};
        dcb = int'(cb_of(kr, kg, kb)) - int'(cb_of(sr, sg, sb));
        dcr = int'(cr_of(kr, kg, kb)) - int'(cr_of(sr, sg, sb));
        dist_q = isqrt(longint'(dcb * dcb + dcr * dcr) * 65536);
        nq = longint'(sh_near) << 8;
        fq = longint'(sh_far) << 8;
        if (dist_q < nq) mask = 65536;
        else if (dist_q < fq) mask = ((fq - dist_q) << 16) / (fq - nq);
        else return res;
        if (mask >= 65536) return '{rr, rg, rb, ckbr_pkg::KC_REPLACE};
        return '{mix_channel(sr, kr, rr, mask), mix_channel(sg, kg, rg, mask),
                 mix_channel(sb, kb, rb, mask), ckbr_pkg::KC_BLEND};
    endfunction

    // hold valid across back-to-back writes; setup drops it at the end
    task automatic write_reg(ckbr_pkg::t_cfg_idx idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            ckbr_pkg::CFG_ENABLE:        sh_enable = val[0];
            ckbr_pkg::CFG_KEY_COLOR:     sh_key    = val;
            ckbr_pkg::CFG_NEAR_TOL:      sh_near   = val[8:0];
            ckbr_pkg::CFG_FAR_TOL:       sh_far    = val[8:0];
            ckbr_pkg::CFG_REPLACE_MODE:  sh_mode   = val[0];
            ckbr_pkg::CFG_REPLACE_COLOR: sh_repl   = val;
            default: ;
        endcase
    endtask

    task automatic setup(logic en, logic [23:0] key, logic [8:0] nt, logic [8:0] ft,
                         logic md, logic [23:0] rc);
        write_reg(ckbr_pkg::CFG_ENABLE, 24'(en));
        write_reg(ckbr_pkg::CFG_KEY_COLOR, key);
        write_reg(ckbr_pkg::CFG_NEAR_TOL, 24'(nt));
        write_reg(ckbr_pkg::CFG_FAR_TOL, 24'(ft));
        write_reg(ckbr_pkg::CFG_REPLACE_MODE, 24'(md));
        write_reg(ckbr_pkg::CFG_REPLACE_COLOR, rc);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                              logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                              logic has_exp, t_result fixed);
        t_result e;
        if (!no_idle && $urandom_range(0, 9) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_src_red    <= sr;
        i_src_green  <= sg;
        i_src_blue   <= sb;
        i_back_red   <= br;
        i_back_green <= bg;
        i_back_blue  <= bb;
        e = has_exp ? fixed : key_pixel(sr, sg, sb, br, bg, bb);
        do @(posedge i_clk); while (!o_in_ready);
        pixel_q.push_back(e);
        if (e.kclass == ckbr_pkg::KC_BLEND) n_blend++;
        if (e.kclass == ckbr_pkg::KC_REPLACE) n_repl++;
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stall bursts, plus a long hold requested by the stimulus
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap      <= 0;
        end else if (rx_hold) begin
            i_out_ready <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap      <= rx_gap - 1;
            i_out_ready <= (rx_gap == 1);
        end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            rx_gap      <= int'($urandom_range(1, 17));
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result e, got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_out_red, o_out_green, o_out_blue, ckbr_pkg::t_key_class'(o_key_class)};
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %h", got);
            end else begin
                e = pixel_q.pop_front();
                n_checked++;
                if (got !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel %0d: expected r%h g%h b%h k%0d got r%h g%h b%h k%0d",
                                 n_checked, e.red, e.green, e.blue, e.kclass,
                                 got.red, got.green, got.blue, got.kclass);
                end
            end
        end
    end

    t_row dir_rows[$];

    task automatic add_row(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                           logic [7:0] br, logic [7:0] bg, logic [7:0] bb,
                           logic has_exp, t_result e);
        t_row r;
        r = '{sr, sg, sb, br, bg, bb, has_exp, e};
        dir_rows.push_back(r);
    endtask

    task automatic run_rows();
        foreach (dir_rows[i])
            send_pixel(dir_rows[i].sr, dir_rows[i].sg, dir_rows[i].sb, dir_rows[i].br,
                       dir_rows[i].bg, dir_rows[i].bb, dir_rows[i].has_exp, dir_rows[i].exp);
        dir_rows.delete();
        idle_input();
    endtask

    // source colors near the key hit the band more often
    task automatic random_pixel(logic [23:0] near_col);
        logic [7:0] c[3];
        for (int k = 0; k < 3; k++) begin
            c[k] = near_col[23 - 8 * k -: 8];
            if ($urandom_range(0, 2) == 0) c[k] = 8'($urandom);
            else c[k] = 8'(int'(c[k]) + $urandom_range(0, 60) - 30);
        end
        send_pixel(c[0], c[1], c[2], 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
    endtask

    task automatic random_phase(int n);
        logic [8:0] a, b;
        logic [23:0] key;
        key = 24'($urandom);
        a = $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'($urandom_range(0, 80));
        b = $urandom_range(0, 3) == 0 ? 9'($urandom) : 9'(a + $urandom_range(0, 60));
        setup($urandom_range(0, 7) != 0, key, a, b, 1'($urandom), 24'($urandom));
        repeat (n) random_pixel(key);
        idle_input();
        drain();
    endtask

    initial begin
        cycles = 0;
        mismatches = 0;
        n_checked = 0;
        n_blend = 0;
        n_repl = 0;
        no_idle = 0;
        rx_hold = 0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = ckbr_pkg::CFG_ENABLE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        {i_src_red, i_src_green, i_src_blue} = '0;
        {i_back_red, i_back_green, i_back_blue} = '0;
        sh_enable = 1'b0;
        sh_key = 24'd255;
        sh_near = 9'd50;
        sh_far = 9'd70;
        sh_mode = 1'b0;
        sh_repl = 24'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset the block is disabled: pass through
        add_row(8'd0, 8'd0, 8'd255, 8'd9, 8'd9, 8'd9, 1'b1,
                '{8'd0, 8'd0, 8'd255, ckbr_pkg::KC_KEEP});
        add_row(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1,
                '{8'd255, 8'd255, 8'd255, ckbr_pkg::KC_KEEP});
        run_rows();
        drain();

        // pure green key, background replace
        setup(1'b1, 24'h00FF00, 9'd40, 9'd80, 1'b0, 24'h123456);
        add_row(8'd0, 8'd255, 8'd0, 8'd11, 8'd22, 8'd33, 1'b1,
                '{8'd11, 8'd22, 8'd33, ckbr_pkg::KC_REPLACE});
        add_row(8'd255, 8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 1'b0, '0);
        add_row(8'd255, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3, 1'b0, '0);
        add_row(8'd0, 8'd0, 8'd0, 8'hAA, 8'h55, 8'hFF, 1'b0, '0);
        add_row(8'd40, 8'd200, 8'd40, 8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        add_row(8'd90, 8'd200, 8'd70, 8'hFF, 8'h00, 8'hFF, 1'b0, '0);
        add_row(8'd120, 8'd200, 8'd90, 8'h00, 8'hFF, 8'h00, 1'b0, '0);
        run_rows();
        drain();

        // fixed replace color
        setup(1'b1, 24'h00FF00, 9'd40, 9'd80, 1'b1, 24'hFFFFFF);
        add_row(8'd0, 8'd255, 8'd0, 8'd11, 8'd22, 8'd33, 1'b1,
                '{8'd255, 8'd255, 8'd255, ckbr_pkg::KC_REPLACE});
        add_row(8'd90, 8'd200, 8'd70, 8'h00, 8'h00, 8'h00, 1'b0, '0);
        run_rows();
        drain();

        // empty band: near above far; then near zero, far max; then near and far both max
        setup(1'b1, 24'hFF00FF, 9'd300, 9'd100, 1'b0, 24'h0);
        add_row(8'd0, 8'd255, 8'd0, 8'd1, 8'd1, 8'd1, 1'b0, '0);
        add_row(8'd255, 8'd0, 8'd255, 8'd7, 8'd8, 8'd9, 1'b1,
                '{8'd7, 8'd8, 8'd9, ckbr_pkg::KC_REPLACE});
        run_rows();
        drain();
        setup(1'b1, 24'hFFFFFF, 9'd0, 9'd511, 1'b0, 24'h0);
        add_row(8'd255, 8'd255, 8'd255, 8'd4, 8'd5, 8'd6, 1'b0, '0);
        add_row(8'd0, 8'd0, 8'd255, 8'd4, 8'd5, 8'd6, 1'b0, '0);
        add_row(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, '0);
        run_rows();
        drain();
        setup(1'b1, 24'h000000, 9'd511, 9'd511, 1'b1, 24'hABCDEF);
        add_row(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1,
                '{8'hAB, 8'hCD, 8'hEF, ckbr_pkg::KC_REPLACE});
        run_rows();
        drain();

        // fill the pipe against a held receiver
        setup(1'b1, 24'h00FF00, 9'd20, 9'd90, 1'b0, 24'h0);
        rx_hold = 1;
        fork
            begin
                repeat (3 * PIPE_LAT) @(posedge i_clk);
                rx_hold = 0;
            end
            repeat (80) random_pixel(24'h00FF00);
        join
        idle_input();
        drain();

        for (int p = 0; p < 12; p++) random_phase(N_RANDOM / 12);
        no_idle = 1;
        random_phase(60);

        $display("checked %0d pixels (%0d blended, %0d replaced) over many key settings",
                 n_checked, n_blend, n_repl);
        if (mismatches == 0 && pixel_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d pixels missing", mismatches, pixel_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
